// File: src/vdm_pkg.sv
package vdm_pkg;

  localparam int unsigned MAX_DIMS = 256;
  localparam int unsigned CNT_W    = $clog2(MAX_DIMS + 1);

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned TERM_W   = 2 * DIFF_W;
  localparam int unsigned ACC_W    = 41;
  localparam int unsigned RAD_W    = ACC_W - 1;
  localparam int unsigned ROOT_W   = 21;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // highest even power of two that fits the radicand
  localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (RAD_W - 2);

  typedef enum logic [1:0] {
    MODE_L1   = 2'd0,
    MODE_L2   = 2'd1,
    MODE_LINF = 2'd2,
    MODE_DOT  = 2'd3
  } mode_e;

endpackage

// File: src/vector_distance_metric.sv
// Streaming vector distance unit. Coordinate pairs come in one request at a
// time; metric_mode_i picks L1, L2, L-infinity or dot product, and the mode
// in force when a pair is accepted governs that pair. Each pair goes through
// the shared 17x17 multiplier / difference stage into a term register, then
// through the 41-bit saturating add or max compare. The final pair then loads
// the output register, in L2 mode after the bit-serial square root (20 steps
// plus handoff). The result sits in an output register; a new vector can
// stream in while it waits, but the next final pair stalls until that result
// is taken. Sums clamp to the 41-bit signed range, and overflow_o also flags
// more than 256 pairs.
module vector_distance_metric (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         metric_mode_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vdm_pkg::COORD_W-1:0] coord_a_i,
  input  logic signed [vdm_pkg::COORD_W-1:0] coord_b_i,
  input  logic                               last_pair_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vdm_pkg::ACC_W-1:0]   metric_value_o,
  output logic                               overflow_o
);
  import vdm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  mode_e  mode_q, item_mode_q;
  logic   last_q;
  logic   sat_q;
  logic [CNT_W-1:0] cnt_q;
  logic signed [ACC_W-1:0] acc_q, acc_next, term_wide, sat_sum;
  logic signed [ACC_W:0]   sum;
  logic signed [TERM_W-1:0] term;
  logic add_ovf;
  logic accept, out_free;
  logic root_start, root_done;
  logic [RAD_W-1:0]  root_in;
  logic [ROOT_W-1:0] root;
  logic out_valid_q, out_ovf_q;
  logic signed [ACC_W-1:0] out_value_q, result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  vdm_term u_term (
    .clk_i     (clk_i),
    .load_i    (accept),
    .mode_i    (mode_q),
    .coord_a_i (coord_a_i),
    .coord_b_i (coord_b_i),
    .term_o    (term)
  );

  assign term_wide = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
  assign sum       = {acc_q[ACC_W-1], acc_q} + {term_wide[ACC_W-1], term_wide};
  assign add_ovf   = sum[ACC_W] != sum[ACC_W-1];
  assign sat_sum   = add_ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  always_comb begin
    unique case (item_mode_q)
      MODE_LINF: acc_next = (term_wide > acc_q) ? term_wide : acc_q;
      default:   acc_next = sat_sum;
    endcase
  end

  // negative radicand only arises from mixed modes; its root is zero
  assign root_start = (state_q == ST_ACC) && last_q && (item_mode_q == MODE_L2);
  assign root_in    = acc_next[ACC_W-1] ? '0 : acc_next[RAD_W-1:0];

  vdm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (root_in),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign result = (item_mode_q == MODE_L2) ? {{(ACC_W-ROOT_W){1'b0}}, root} : acc_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_ACC;
      ST_ACC: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (item_mode_q == MODE_L2) begin
          state_d = ST_ROOT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ROOT: if (root_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_L1;
      item_mode_q <= MODE_L1;
      last_q      <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= mode_e'(metric_mode_i);
      end
      if (accept) begin
        item_mode_q <= mode_q;
        last_q      <= last_pair_i;
        if (cnt_q == CNT_W'(MAX_DIMS)) begin
          sat_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_ACC) begin
        acc_q <= acc_next;
        if (add_ovf && item_mode_q != MODE_LINF) begin
          sat_q <= 1'b1;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_value_q <= result;
        out_ovf_q   <= sat_q;
        acc_q       <= '0;
        cnt_q       <= '0;
        sat_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign metric_value_o = out_value_q;
  assign overflow_o     = out_ovf_q;

endmodule

// File: src/vdm_term.sv
module vdm_term (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  vdm_pkg::mode_e                    mode_i,
  input  logic signed [vdm_pkg::COORD_W-1:0] coord_a_i,
  input  logic signed [vdm_pkg::COORD_W-1:0] coord_b_i,
  output logic signed [vdm_pkg::TERM_W-1:0]  term_o
);
  import vdm_pkg::*;

  logic signed [DIFF_W-1:0] a_ext, b_ext, diff;
  logic        [DIFF_W-1:0] mag;
  logic signed [DIFF_W-1:0] op_x, op_y;
  logic signed [TERM_W-1:0] prod;
  logic signed [TERM_W-1:0] term_d, term_q;

  assign a_ext = {coord_a_i[COORD_W-1], coord_a_i};
  assign b_ext = {coord_b_i[COORD_W-1], coord_b_i};
  assign diff  = a_ext - b_ext;
  assign mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // one multiplier serves both the squared difference and the product
  assign op_x = (mode_i == MODE_DOT) ? a_ext : diff;
  assign op_y = (mode_i == MODE_DOT) ? b_ext : diff;
  assign prod = op_x * op_y;

  always_comb begin
    unique case (mode_i)
      MODE_L2, MODE_DOT: term_d = prod;
      default:           term_d = {{(TERM_W-DIFF_W){1'b0}}, mag};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

// File: src/vdm_isqrt.sv
module vdm_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vdm_pkg::RAD_W-1:0]     value_i,
  output logic                          done_o,
  output logic [vdm_pkg::ROOT_W-1:0]    root_o
);
  import vdm_pkg::*;

  logic             busy_q, done_q;
  logic [RAD_W-1:0] rem_q, res_q, bit_q;
  logic [RAD_W:0]   trial;
  logic             take;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one result bit per step, radix-4 restoring form
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      bit_q <= ROOT_BIT0;
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - trial[RAD_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// File: src/vdm_checker.sv
module vdm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [vdm_pkg::ACC_W-1:0]   metric_value_o,
  input logic                               overflow_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(metric_value_o)
      && $stable(overflow_o))
    else $error("result changed while stalled");

  // each accepted pair keeps the unit busy, so no two pairs are taken back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // a new result is only loaded while input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a busy cycle");

endmodule

bind vector_distance_metric vdm_checker u_vdm_checker (.*);

// File: bench/vector_distance_metric_tb.sv
`timescale 1ns / 1ps

module vector_distance_metric_tb;
  import vdm_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 6;
  // covers the L2 square root and output handoff with room to spare
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PAIRS  = 360;

  localparam longint SUM_MAX = longint'(ACC_MAX);
  localparam longint SUM_MIN = longint'(ACC_MIN);

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic                    ovf;
  } metric_result_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  metric_mode_i = MODE_L1;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic signed [COORD_W-1:0]   coord_a_i     = '0;
  logic signed [COORD_W-1:0]   coord_b_i     = '0;
  logic                        last_pair_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic signed [ACC_W-1:0]     metric_value_o;
  logic                        overflow_o;

  vector_distance_metric dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .metric_mode_i  (metric_mode_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coord_a_i      (coord_a_i),
    .coord_b_i      (coord_b_i),
    .last_pair_i    (last_pair_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .metric_value_o (metric_value_o),
    .overflow_o     (overflow_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // predictor state
  mode_e          cur_mode = MODE_L1;
  longint         run_sum  = 0;
  int unsigned    pair_cnt = 0;
  bit             sum_sat  = 1'b0;
  metric_result_t pending_results[$];

  int unsigned    fail_cnt   = 0;
  bit             calm       = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    cycle_cnt  = 0;
  metric_result_t want;

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic longint sum_clamped(longint acc, longint inc);
    longint s;
    s = acc + inc;
    if (s > SUM_MAX) begin
      sum_sat = 1'b1;
      return SUM_MAX;
    end
    if (s < SUM_MIN) begin
      sum_sat = 1'b1;
      return SUM_MIN;
    end
    return s;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint trial;
    r = 0;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      trial = r | (longint'(1) << k);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic void accumulate_pair(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b,
                                          logic last);
    longint diff;
    longint mag;
    longint res;
    metric_result_t r;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? -diff : diff;
    if (pair_cnt >= MAX_DIMS) begin
      sum_sat  = 1'b1;
      pair_cnt = MAX_DIMS;
    end else begin
      pair_cnt++;
    end
    case (cur_mode)
      MODE_L1:   run_sum = sum_clamped(run_sum, mag);
      MODE_L2:   run_sum = sum_clamped(run_sum, diff * diff);
      MODE_LINF: if (mag > run_sum) run_sum = mag;
      default:   run_sum = sum_clamped(run_sum, longint'(a) * longint'(b));
    endcase
    if (last) begin
      if (cur_mode == MODE_L2) res = (run_sum > 0) ? floor_sqrt(run_sum) : 0;
      else res = run_sum;
      r.value = res[ACC_W-1:0];
      r.ovf   = sum_sat;
      pending_results.push_back(r);
      run_sum  = 0;
      pair_cnt = 0;
      sum_sat  = 1'b0;
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return COORD_W'($urandom);
    if (pick < 8) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        3:       return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    return COORD_W'($urandom_range(0, 16) - 8);
  endfunction

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_pair(input logic signed [COORD_W-1:0] a,
                           input logic signed [COORD_W-1:0] b,
                           input logic last);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    coord_a_i   <= a;
    coord_b_i   <= b;
    last_pair_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    accumulate_pair(a, b, last);
  endtask

  // hold off requests until every result is out and the pipe has drained
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    settle();
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    metric_mode_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_repeated(input logic signed [COORD_W-1:0] a,
                               input logic signed [COORD_W-1:0] b,
                               input int unsigned n);
    for (int k = 1; k <= n; k++) send_pair(a, b, k == n);
  endtask

  task automatic test_directed();
    // first vector runs under the reset mode (L1)
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0001, 16'shffff, 1'b1);
    write_mode(MODE_L2);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh0003, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    write_mode(MODE_LINF);
    send_pair(16'sh0005, 16'shfffb, 1'b0);
    send_pair(16'shff9c, 16'sh0064, 1'b0);
    send_pair(16'sh0007, 16'sh0007, 1'b1);
    send_pair(16'sh8000, 16'sh0000, 1'b1);
    write_mode(MODE_DOT);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh0001, 16'sh0001, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    write_mode(MODE_L1);
    send_pair(16'sh1234, 16'sh0000, 1'b1);
  endtask

  task automatic test_long_vectors();
    // exactly the limit, sum just under the clamp: no flag
    write_mode(MODE_L2);
    send_repeated(16'sh7fff, 16'sh8000, MAX_DIMS);
    // one pair more: pair limit and clamped sum
    send_repeated(16'sh7fff, 16'sh8000, MAX_DIMS + 1);
  endtask

  task automatic test_mode_switch();
    // negative dot sum finished as L2 -> root of a negative is zero
    write_mode(MODE_DOT);
    send_pair(16'shff9c, 16'sh0064, 1'b0);
    send_pair(16'shff9c, 16'sh0064, 1'b0);
    write_mode(MODE_L2);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    // negative dot sum finished as L-infinity
    write_mode(MODE_DOT);
    send_pair(16'shff9c, 16'sh0064, 1'b0);
    write_mode(MODE_LINF);
    send_pair(16'sh0001, 16'sh0000, 1'b1);
    // L1 sum finished as L2
    write_mode(MODE_L1);
    send_pair(16'sh0064, 16'sh0000, 1'b0);
    write_mode(MODE_L2);
    send_pair(16'sh0003, 16'sh0000, 1'b1);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned switch_at;
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 3) == 0) write_mode(mode_e'($urandom_range(0, 3)));
      else if ($urandom_range(0, 19) == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 6);
      else if (pick < 98) len = $urandom_range(7, 24);
      else len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 14);
      switch_at = 0;
      if (len > 1 && $urandom_range(0, 9) == 0) switch_at = $urandom_range(2, len);
      for (int k = 1; k <= len; k++) begin
        if (k == switch_at) write_mode(mode_e'($urandom_range(0, 3)));
        if (!calm && $urandom_range(0, 3) == 0) idle_cycles(gap_len());
        send_pair(rand_coord(), rand_coord(), k == len);
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: metric_value %0d overflow %0d",
               metric_value_o, overflow_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (metric_value_o !== want.value) begin
          $error("metric_value: expected %0d, got %0d", want.value, metric_value_o);
          fail_cnt++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0d, got %0d", want.ovf, overflow_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** vector_distance_metric: FAILED **");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_long_vectors();
    test_mode_switch();
    test_random();
    settle();
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("** vector_distance_metric: PASSED **");
    end else begin
      $display("** vector_distance_metric: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/vdm_pkg.sv
src/vdm_term.sv
src/vdm_isqrt.sv
src/vector_distance_metric.sv
src/vdm_checker.sv
bench/vector_distance_metric_tb.sv
